### rtl/core/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
// No dependencies; rmq_front, rmq_div, the top and the bench refer to it by scoped names.
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int IN_W          = 16;
	localparam int SUM_W         = 17;   // off-diagonal sums and differences
	localparam int QUO_BITS      = 15;   // quotient bits kept; larger saturates anyway

	localparam logic [1:0] PICK_X = 2'd0;
	localparam logic [1:0] PICK_Y = 2'd1;
	localparam logic [1:0] PICK_Z = 2'd2;
	localparam logic [1:0] PICK_W = 2'd3;

	typedef struct packed {
		logic [1:0] pick;
		logic       flag;
	} side_t;

endpackage

### rtl/core/rmq_front.sv
// Front end: candidates and off-diagonal terms (stage 1), largest pick,
// radicand and per-component numerators (stage 2). Uses rmq_pkg.
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int EW        = 20,
	parameter int RB        = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rmq_pkg::IN_W-1:0]   r00,
	input  logic signed [rmq_pkg::IN_W-1:0]   r01,
	input  logic signed [rmq_pkg::IN_W-1:0]   r02,
	input  logic signed [rmq_pkg::IN_W-1:0]   r10,
	input  logic signed [rmq_pkg::IN_W-1:0]   r11,
	input  logic signed [rmq_pkg::IN_W-1:0]   r12,
	input  logic signed [rmq_pkg::IN_W-1:0]   r20,
	input  logic signed [rmq_pkg::IN_W-1:0]   r21,
	input  logic signed [rmq_pkg::IN_W-1:0]   r22,
	output logic [2*RB-1:0]                   rad_s2,
	output rmq_pkg::side_t                    side_s2,
	output logic signed [rmq_pkg::SUM_W-1:0]  a_s2 [4]
);

	localparam int SW = rmq_pkg::SUM_W;
	localparam logic signed [EW-1:0] ONE = {{(EW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	logic signed [EW-1:0] m00, m11, m22;
	logic signed [EW-1:0] e_s1 [4];
	logic signed [SW-1:0] s01_s1, s20_s1, s12_s1, d12_s1, d20_s1, d01_s1;

	logic [1:0]           p01, p23, pick;
	logic signed [EW-1:0] e01, e23, emax;
	logic                 flag;
	logic signed [SW-1:0] a_c [4];

	assign m00 = EW'(r00);
	assign m11 = EW'(r11);
	assign m22 = EW'(r22);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1[0] <= m00 - m11 - m22 + ONE;
			e_s1[1] <= m11 - m00 - m22 + ONE;
			e_s1[2] <= m22 - m00 - m11 + ONE;
			e_s1[3] <= m00 + m11 + m22 + ONE;
			s01_s1  <= SW'(r01) + SW'(r10);
			s20_s1  <= SW'(r20) + SW'(r02);
			s12_s1  <= SW'(r12) + SW'(r21);
			d12_s1  <= SW'(r12) - SW'(r21);
			d20_s1  <= SW'(r20) - SW'(r02);
			d01_s1  <= SW'(r01) - SW'(r10);
		end
	end

	// pairwise tree; lower index keeps a tie at both levels
	always_comb begin
		p01  = (e_s1[1] > e_s1[0]) ? rmq_pkg::PICK_Y : rmq_pkg::PICK_X;
		e01  = (e_s1[1] > e_s1[0]) ? e_s1[1] : e_s1[0];
		p23  = (e_s1[3] > e_s1[2]) ? rmq_pkg::PICK_W : rmq_pkg::PICK_Z;
		e23  = (e_s1[3] > e_s1[2]) ? e_s1[3] : e_s1[2];
		pick = (e23 > e01) ? p23 : p01;
		emax = (e23 > e01) ? e23 : e01;
		flag = emax[EW-1] || (emax == '0);
		a_c[0] = '0;
		a_c[1] = '0;
		a_c[2] = '0;
		a_c[3] = '0;
		case (pick)
			rmq_pkg::PICK_X: begin
				a_c[1] = s01_s1;
				a_c[2] = s20_s1;
				a_c[3] = d12_s1;
			end
			rmq_pkg::PICK_Y: begin
				a_c[0] = s01_s1;
				a_c[2] = s12_s1;
				a_c[3] = d20_s1;
			end
			rmq_pkg::PICK_Z: begin
				a_c[0] = s20_s1;
				a_c[1] = s12_s1;
				a_c[3] = d01_s1;
			end
			default: begin
				a_c[0] = d12_s1;
				a_c[1] = d20_s1;
				a_c[2] = d01_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2       <= flag ? '0 :
				((2*RB)'(unsigned'(emax[EW-2:0])) << (FRAC_BITS - 2));
			side_s2.pick <= pick;
			side_s2.flag <= flag;
			a_s2         <= a_c;
		end
	end

endmodule

### rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, RB stages.
// Standalone; no package use.
module rmq_sqrt #(
	parameter int RB = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RB-1:0] rad,
	output logic [RB-1:0]   root
);

	logic [RB+2:0]   rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [2*RB-1:0] rad_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_st
		logic [RB+2:0]   rem_i, rsh, trial;
		logic [RB-1:0]   root_i;
		logic [2*RB-1:0] rad_i;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
		end

		// remainder never exceeds twice the partial root
		assign rsh   = {rem_i[RB:0], rad_i[2*RB-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = rsh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rsh - trial : rsh;
				root_s[k] <= {root_i[RB-2:0], ge};
				rad_s[k]  <= rad_i << 2;
			end
		end
	end

	assign root = root_s[RB-1];

endmodule

### rtl/core/rmq_div.sv
// Pipelined rounded divide: round(|a| * 2^FRAC_BITS / (4*v)), restoring,
// one quotient bit per stage, QUO_BITS + 2 stages. Uses rmq_pkg.
module rmq_div #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int RB        = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rmq_pkg::SUM_W-1:0] a,
	input  logic [RB-1:0]                    v,
	output logic [rmq_pkg::QUO_BITS-1:0]     q,
	output logic                             ovf,
	output logic                             neg
);

	localparam int SW = rmq_pkg::SUM_W;
	localparam int QB = rmq_pkg::QUO_BITS;
	localparam int DW = ((SW + FRAC_BITS > RB + 2) ? SW + FRAC_BITS : RB + 2) + 1;
	localparam int CW = ((DW > RB + 2 + QB) ? DW : RB + 2 + QB) + 1;

	logic [SW-1:0]   mag;
	logic [DW-1:0]   num_s1;
	logic [RB+1:0]   den_s1, den_s2;
	logic            neg_s1, neg_s2, ovf_s2;
	logic [CW-1:0]   num_s2;

	logic [CW-1:0]   rem_s [QB];
	logic [RB+1:0]   den_s [QB];
	logic [QB-1:0]   q_s   [QB];
	logic            ovf_s [QB];
	logic            neg_s [QB];

	assign mag = a[SW-1] ? unsigned'(-a) : unsigned'(a);

	// adding 2v (half the divisor) turns truncation into round half away
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= (DW'(mag) << FRAC_BITS) + DW'({v, 1'b0});
			den_s1 <= {v, 2'b00};
			neg_s1 <= a[SW-1];
			num_s2 <= CW'(num_s1);
			den_s2 <= den_s1;
			neg_s2 <= neg_s1;
			ovf_s2 <= CW'(num_s1) >= (CW'(den_s1) << QB);
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_st
		logic [CW-1:0] rem_i, dsh;
		logic [RB+1:0] den_i;
		logic [QB-1:0] q_i;
		logic          ovf_i, neg_i, ge;

		if (j == 0) begin : g_first
			assign rem_i = num_s2;
			assign den_i = den_s2;
			assign q_i   = '0;
			assign ovf_i = ovf_s2;
			assign neg_i = neg_s2;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign q_i   = q_s[j-1];
			assign ovf_i = ovf_s[j-1];
			assign neg_i = neg_s[j-1];
		end

		assign dsh = CW'(den_i) << (QB - 1 - j);
		assign ge  = rem_i >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem_i - dsh : rem_i;
				den_s[j] <= den_i;
				q_s[j]   <= {q_i[QB-2:0], ge};
				ovf_s[j] <= ovf_i;
				neg_s[j] <= neg_i;
			end
		end
	end

	assign q   = q_s[QB-1];
	assign ovf = ovf_s[QB-1];
	assign neg = neg_s[QB-1];

endmodule

### rtl/core/rotation_matrix_to_quaternion_top.sv
// RB = root bits derived from FRAC_BITS (16 at Q1.14).
// Throughput one transfer per cycle; the whole pipeline advances together and
// holds while the output register is full and m_tready is low.
// Reset (arst_n, asynchronous, active low) clears the valid bits only.
// Stages: candidates, pick, RB root stages, 2 + QUO_BITS divide stages, output.
// Top level; instantiates rmq_front, rmq_sqrt, rmq_div; uses rmq_pkg.
module rotation_matrix_to_quaternion_top #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // qx, qy, qz, qw
	output logic [2:0]   m_tuser    // largest_pick[1:0], not_rotation
);

	localparam int SW  = rmq_pkg::SUM_W;
	localparam int QB  = rmq_pkg::QUO_BITS;
	localparam int EW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
	localparam int NSW = EW - 1 + FRAC_BITS - 2;
	localparam int RB  = (NSW + 1) / 2;
	localparam int L   = RB + QB + 5;
	localparam int DL  = RB + QB + 2;
	localparam logic signed [15:0] HI_V = (FRAC_BITS >= 15) ? 16'sh7FFF : 16'(1 << FRAC_BITS);
	localparam logic signed [15:0] LO_V = (FRAC_BITS >= 15) ? 16'sh8000 : -HI_V;

	logic                 adv;
	logic [L-1:0]         vld_q;

	logic [2*RB-1:0]      rad_s2;
	rmq_pkg::side_t       side_s2;
	logic signed [SW-1:0] a_s2 [4];
	logic [RB-1:0]        root;

	rmq_pkg::side_t       side_d [DL];
	logic signed [SW-1:0] a_d [RB][4];
	logic [RB-1:0]        v_d [QB+2];

	logic [QB-1:0]        dq   [4];
	logic                 dovf [4];
	logic                 dneg [4];
	logic signed [15:0]   cval [4];

	logic [63:0]          tdata_q;
	logic [2:0]           tuser_q;

	assign adv      = !vld_q[L-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[L-1];
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	rmq_front #(.FRAC_BITS(FRAC_BITS), .EW(EW), .RB(RB)) u_front (
		.clk     (clk),
		.en      (adv),
		.r00     ($signed(s_tdata[15:0])),
		.r01     ($signed(s_tdata[31:16])),
		.r02     ($signed(s_tdata[47:32])),
		.r10     ($signed(s_tdata[63:48])),
		.r11     ($signed(s_tdata[79:64])),
		.r12     ($signed(s_tdata[95:80])),
		.r20     ($signed(s_tdata[111:96])),
		.r21     ($signed(s_tdata[127:112])),
		.r22     ($signed(s_tdata[143:128])),
		.rad_s2  (rad_s2),
		.side_s2 (side_s2),
		.a_s2    (a_s2)
	);

	rmq_sqrt #(.RB(RB)) u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s2),
		.root (root)
	);

	// side band and numerators ride along with the root and divide stages
	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s2;
			for (int i = 1; i < DL; i++) begin
				side_d[i] <= side_d[i-1];
			end
			a_d[0] <= a_s2;
			for (int i = 1; i < RB; i++) begin
				a_d[i] <= a_d[i-1];
			end
			v_d[0] <= root;
			for (int i = 1; i < QB + 2; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_comp
		logic signed [16:0] sq;
		logic [31:0]        vw;

		rmq_div #(.FRAC_BITS(FRAC_BITS), .RB(RB)) u_div (
			.clk (clk),
			.en  (adv),
			.a   (a_d[RB-1][k]),
			.v   (root),
			.q   (dq[k]),
			.ovf (dovf[k]),
			.neg (dneg[k])
		);

		assign sq = dneg[k] ? -$signed({2'b00, dq[k]}) : $signed({2'b00, dq[k]});
		assign vw = 32'(v_d[QB+1]);

		always_comb begin
			if (side_d[DL-1].flag) begin
				cval[k] = '0;
			end else if (side_d[DL-1].pick == 2'(k)) begin
				cval[k] = (vw > 32'(HI_V)) ? HI_V : 16'(vw);
			end else if (dovf[k]) begin
				cval[k] = dneg[k] ? LO_V : HI_V;
			end else if (sq > 17'(HI_V)) begin
				cval[k] = HI_V;
			end else if (sq < 17'(LO_V)) begin
				cval[k] = LO_V;
			end else begin
				cval[k] = sq[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= {cval[3], cval[2], cval[1], cval[0]};
			tuser_q <= {side_d[DL-1].flag, side_d[DL-1].pick};
		end
	end

`ifndef SYNTHESIS
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == 64'd0)
		else $error("not_rotation result with nonzero components");

	a_pick_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] && (m_tuser[1:0] == rmq_pkg::PICK_W)
		|-> !m_tdata[63] && (m_tdata[63:48] != 16'd0))
		else $error("picked w component not positive");

	a_in_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transfer lost at pipeline entry");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[L-2] && !adv |=> vld_q[L-2])
		else $error("pipeline stage dropped an item during a stall");
`endif

endmodule

### verif/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rotation_matrix_to_quaternion_top: directed table then random matrices.
// Depends on rmq_pkg and the top module; predicts each quaternion and checks it per field.
module rotation_matrix_to_quaternion_top_tb;

	localparam int FB  = rmq_pkg::FRAC_BITS_DEF;
	localparam int ONE = 1 << FB;
	localparam int LAT = 60;

	typedef struct packed {
		logic signed [15:0] qx, qy, qz, qw;
		logic [1:0]         pick;
		logic               flag;
	} quat_t;

	typedef struct {
		logic [143:0] mat;
		bit           known;
		quat_t        res;
	} row_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [143:0] s_tdata;
	logic [63:0]  m_tdata;
	logic [2:0]   m_tuser;

	quat_t  quat_q[$];
	int     errors = 0;
	bit     hold_rx = 0;
	int     sent = 0;

	rotation_matrix_to_quaternion_top i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// fast integer root by bisection
	function automatic longint root(longint n);
		longint lo = 0, hi = 1 << 24, mid;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint rdiv(longint s, longint v);
		longint mag, den, q;
		if (v == 0) return 0;
		mag = (s < 0 ? -s : s) << FB;
		den = 4 * v;
		q = (mag + den / 2) / den;
		return s < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] clamp(longint x);
		longint hi = ONE > 32767 ? 32767 : ONE;
		longint lo = -ONE < -32768 ? -32768 : -ONE;
		if (x > hi) x = hi;
		if (x < lo) x = lo;
		return x[15:0];
	endfunction

	function automatic quat_t quat_of(logic [143:0] d);
		longint m[9], e[4], q[4], v;
		longint s01, s20, s12, d12, d20, d01;
		int p = 0;
		quat_t r;
		for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
		e[0] = m[0] - m[4] - m[8] + ONE;
		e[1] = -m[0] + m[4] - m[8] + ONE;
		e[2] = -m[0] - m[4] + m[8] + ONE;
		e[3] = m[0] + m[4] + m[8] + ONE;
		for (int i = 1; i < 4; i++) if (e[i] > e[p]) p = i;
		q = '{0, 0, 0, 0};
		r.pick = p[1:0];
		r.flag = e[p] <= 0;
		if (!r.flag) begin
			v = root(e[p] << (FB - 2));
			s01 = m[1] + m[3]; s20 = m[6] + m[2]; s12 = m[5] + m[7];
			d12 = m[5] - m[7]; d20 = m[6] - m[2]; d01 = m[1] - m[3];
			q[p] = v;
			case (r.pick)
				rmq_pkg::PICK_X: begin
					q[1] = rdiv(s01, v); q[2] = rdiv(s20, v); q[3] = rdiv(d12, v);
				end
				rmq_pkg::PICK_Y: begin
					q[0] = rdiv(s01, v); q[2] = rdiv(s12, v); q[3] = rdiv(d20, v);
				end
				rmq_pkg::PICK_Z: begin
					q[0] = rdiv(s20, v); q[1] = rdiv(s12, v); q[3] = rdiv(d01, v);
				end
				default: begin
					q[0] = rdiv(d12, v); q[1] = rdiv(d20, v); q[2] = rdiv(d01, v);
				end
			endcase
		end
		r.qx = clamp(q[0]); r.qy = clamp(q[1]); r.qz = clamp(q[2]); r.qw = clamp(q[3]);
		return r;
	endfunction

	function automatic logic [143:0] pack9(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
		int a[9] = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[16*i +: 16] = a[i][15:0];
		return d;
	endfunction

	// random matrix: entries in [-ONE, ONE], or fully random 16-bit words when k is 0 (one draw in ten)
	function automatic logic [143:0] rand_mat();
		logic [143:0] d;
		int k = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			if (k == 0) d[16*i +: 16] = 16'($urandom);
			else d[16*i +: 16] = 16'($signed($urandom_range(0, 2*ONE)) - ONE);
		end
		return d;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic send(logic [143:0] d);
		s_tvalid <= 1;
		s_tdata  <= d;
		quat_q.push_back(quat_of(d));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic gap();
		s_tvalid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// checker on accepted output transfers
	always @(posedge clk) begin
		quat_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
			       m_tuser[1:0], m_tuser[2]};
			if (quat_q.size() == 0) begin
				$display("unexpected transfer %h", m_tdata);
				errors++;
			end else begin
				want = quat_q.pop_front();
				if (got.qx !== want.qx) report("qx", got.qx, want.qx);
				if (got.qy !== want.qy) report("qy", got.qy, want.qy);
				if (got.qz !== want.qz) report("qz", got.qz, want.qz);
				if (got.qw !== want.qw) report("qw", got.qw, want.qw);
				if (got.pick !== want.pick) report("pick", 16'(got.pick), 16'(want.pick));
				if (got.flag !== want.flag) report("flag", 16'(got.flag), 16'(want.flag));
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 0;
				repeat (200) @(posedge clk);
				hold_rx = 0;
			end
			case ($urandom_range(0, 3))
				0: m_tready <= 0;
				default: m_tready <= 1;
			endcase
		end
	end

	row_t tbl[$];

	initial begin
		quat_t chk;
		arst_n = 0; s_tvalid = 0; s_tdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity, each axis half-turn, then extremes and odd matrices
		tbl.push_back('{pack9(ONE,0,0, 0,ONE,0, 0,0,ONE), 1,
			'{16'sd0, 16'sd0, 16'sd0, 16'(ONE), rmq_pkg::PICK_W, 1'b0}});
		tbl.push_back('{pack9(ONE,0,0, 0,-ONE,0, 0,0,-ONE), 1,
			'{16'(ONE), 16'sd0, 16'sd0, 16'sd0, rmq_pkg::PICK_X, 1'b0}});
		tbl.push_back('{pack9(-ONE,0,0, 0,ONE,0, 0,0,-ONE), 1,
			'{16'sd0, 16'(ONE), 16'sd0, 16'sd0, rmq_pkg::PICK_Y, 1'b0}});
		tbl.push_back('{pack9(-ONE,0,0, 0,-ONE,0, 0,0,ONE), 1,
			'{16'sd0, 16'sd0, 16'(ONE), 16'sd0, rmq_pkg::PICK_Z, 1'b0}});
		tbl.push_back('{pack9(-ONE,0,0, 0,-ONE,0, 0,0,-ONE), 0, '0});
		tbl.push_back('{pack9(-32768,0,0, 0,-32768,0, 0,0,-32768), 0, '0});
		tbl.push_back('{pack9(0,0,0, 0,0,0, 0,0,0), 0, '0});
		tbl.push_back('{pack9(32767,32767,32767, 32767,32767,32767, 32767,32767,32767), 0, '0});
		tbl.push_back('{pack9(-32768,-32768,-32768, -32768,-32768,-32768,
			-32768,-32768,-32768), 0, '0});
		tbl.push_back('{pack9(0,-ONE,0, ONE,0,0, 0,0,ONE), 0, '0});
		tbl.push_back('{pack9(ONE,0,0, 0,0,-ONE, 0,ONE,0), 0, '0});
		tbl.push_back('{pack9(0,0,ONE, 0,ONE,0, -ONE,0,0), 0, '0});
		tbl.push_back('{pack9(-32768,32767,-32768, 32767,-32768,32767, -32768,32767,32767), 0, '0});
		tbl.push_back('{pack9(-ONE,1,1, 1,-ONE,1, 1,1,-ONE+2), 0, '0});
		tbl.push_back('{pack9(-ONE,0,0, 0,-ONE,0, 0,0,-ONE+1), 0, '0});
		foreach (tbl[i]) begin
			if (tbl[i].known) begin
				chk = quat_of(tbl[i].mat);
				if (chk !== tbl[i].res) begin
					$display("predictor disagrees on table row %0d", i);
					errors++;
				end
			end
			send(tbl[i].mat);
			if ($urandom_range(0, 1)) gap();
		end
		// sender pauses until drained
		s_tvalid <= 0;
		while (quat_q.size() != 0) @(posedge clk);
		hold_rx = 1;
		for (int i = 0; i < 120; i++) send(rand_mat());
		while (sent < 1215) begin
			for (int b = $urandom_range(1, 30); b > 0; b--) send(rand_mat());
			if ($urandom_range(0, 3) != 0) gap();
		end
		s_tvalid <= 0;
		while (quat_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
